FILE: hw/rtl/circular_ticket_queue_defines.svh
// ----------------------------------------------------------------------------
// Circular ticket queue assertion macros
// Immediate-consequence and next-cycle property macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_TICKET_QUEUE_DEFINES_SVH
`define CIRCULAR_TICKET_QUEUE_DEFINES_SVH

`ifndef SYNTH
// Consequent must hold in the same cycle as the antecedent.
`define CTQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("circular_ticket_queue: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define CTQ_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("circular_ticket_queue: next-cycle check failed");
`else
`define CTQ_ASSERT_IMP(label, clk, rstn, ante, cons)
`define CTQ_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: hw/rtl/ctq_pkg.sv
// ----------------------------------------------------------------------------
// Circular ticket queue package
// Shared types, codes and stream widths for the ticket queue.
// ----------------------------------------------------------------------------
`default_nettype none

package ctq_pkg;

    // Field widths fixed by the stream format.
    localparam int TICKET_W   = 16;
    localparam int CODE_W     = 4;
    localparam int POS_W      = 5;
    localparam int S_TDATA_W  = 32;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = 3;

    // Operation carried in the input tuser.
    typedef enum logic [1:0] {
        OP_ENQ   = 2'd0,
        OP_DEQ   = 2'd1,
        OP_FIND  = 2'd2,
        OP_COUNT = 2'd3
    } ctq_op_t;

    // Result status carried in the output tuser.
    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } ctq_status_t;

    // Control sequencer states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_DEQ  = 2'd1,
        S_FIND = 2'd2
    } ctq_state_t;

    // One stored ticket entry.
    typedef struct packed {
        logic [TICKET_W-1:0] ticket;
        logic [CODE_W-1:0]   kind;
        logic [CODE_W-1:0]   service;
        logic [CODE_W-1:0]   teller;
    } ctq_entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/circular_ticket_queue.sv
// Enqueue and count register their result beat on acceptance; dequeue reads the head
// entry first and gives it from S_DEQ. Find scans from the head to the first hit or
// the last occupied entry, one entry per cycle, bounded by the single read port of the
// entry memory. A new beat is taken once the result is registered and the output is free.
// Reset: synchronous, active low; clears pointers, occupancy, mode and output valid.
// The entry memory is not cleared; only occupied entries are ever read.
// ----------------------------------------------------------------------------
// Circular ticket queue
// Ticket queue with enqueue, dequeue, find and count over a circular store.
// ----------------------------------------------------------------------------
`default_nettype none

`include "circular_ticket_queue_defines.svh"

module circular_ticket_queue #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Mode register: 1 drops the oldest entry on a full enqueue.
    input  wire logic                            cfg_we,
    input  wire logic                            cfg_wdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // ticket[15:0], customer_kind[19:16], service_code[23:20],
    // teller_code[27:24], zero[31:28]
    input  wire logic [ctq_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode[1:0]
    input  wire logic [ctq_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // position_or_count[4:0], out_ticket[20:5], out_customer_kind[24:21],
    // out_service_code[28:25], out_teller_code[32:29], zero[39:33]
    output logic [ctq_pkg::M_TDATA_W-1:0]        m_tdata,
    // status[1:0], dropped_oldest[2]
    output logic [ctq_pkg::M_TUSER_W-1:0]        m_tuser
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
        return (idx == LAST_SLOT) ? '0 : IDX_W'(idx + 1'b1);
    endfunction

    // Control and pointer state.
    ctq_pkg::ctq_state_t          state_reg, state_next;
    logic [IDX_W-1:0]             head_reg, head_next;
    logic [IDX_W-1:0]             tail_reg, tail_next;
    logic [CNT_W-1:0]             occ_reg, occ_next;
    logic                         owf_reg, owf_next;
    logic [ctq_pkg::TICKET_W-1:0] key_reg, key_next;
    logic [ctq_pkg::CODE_W-1:0]   teller_reg, teller_next;
    logic [IDX_W-1:0]             scan_addr_reg, scan_addr_next;
    logic [IDX_W-1:0]             cmp_cnt_reg, cmp_cnt_next;

    // Output register.
    logic                         m_valid_reg, m_valid_next;
    ctq_pkg::ctq_status_t         m_status_reg, m_status_next;
    logic [ctq_pkg::POS_W-1:0]    m_pos_reg, m_pos_next;
    ctq_pkg::ctq_entry_t          m_entry_reg, m_entry_next;
    logic                         m_drop_reg, m_drop_next;

    // Memory ports.
    logic                         wr_en;
    ctq_pkg::ctq_entry_t          wr_data;
    logic                         rd_en;
    logic [IDX_W-1:0]             rd_addr;
    ctq_pkg::ctq_entry_t          rd_data;

    logic                         out_free;
    logic                         s_fire;
    logic                         is_full;
    logic                         scan_hit;
    logic                         scan_last;
    ctq_pkg::ctq_op_t             in_op;

    ctq_entry_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Handshake and decode.
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ctq_pkg::S_IDLE) && out_free;
    assign s_fire    = s_tvalid && s_tready;
    assign in_op     = ctq_pkg::ctq_op_t'(s_tuser);
    assign is_full   = (occ_reg == FULL_CNT);
    assign scan_hit  = (rd_data.ticket == key_reg);
    assign scan_last = (CNT_W'(cmp_cnt_reg) == CNT_W'(occ_reg - CNT_W'(1)));

    assign wr_data.ticket  = s_tdata[15:0];
    assign wr_data.kind    = s_tdata[19:16];
    assign wr_data.service = s_tdata[23:20];
    assign wr_data.teller  = s_tdata[27:24];

    // Next state, memory accesses and result loading.
    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        occ_next       = occ_reg;
        owf_next       = cfg_we ? cfg_wdata : owf_reg;
        key_next       = key_reg;
        teller_next    = teller_reg;
        scan_addr_next = scan_addr_reg;
        cmp_cnt_next   = cmp_cnt_reg;
        m_valid_next   = m_tready ? 1'b0 : m_valid_reg;
        m_status_next  = m_status_reg;
        m_pos_next     = m_pos_reg;
        m_entry_next   = m_entry_reg;
        m_drop_next    = m_drop_reg;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = head_reg;

        unique case (state_reg)
            ctq_pkg::S_IDLE: begin
                if (s_fire) begin
                    m_status_next = ctq_pkg::STAT_OK;
                    m_pos_next    = '0;
                    m_entry_next  = '0;
                    m_drop_next   = 1'b0;
                    unique case (in_op)
                        ctq_pkg::OP_ENQ: begin
                            m_valid_next = 1'b1;
                            if (is_full && !owf_reg) begin
                                m_status_next = ctq_pkg::STAT_FULL;
                            end else begin
                                // A full history-mode enqueue overwrites the oldest slot.
                                if (is_full) begin
                                    head_next   = next_slot(head_reg);
                                    m_drop_next = 1'b1;
                                end else begin
                                    occ_next = CNT_W'(occ_reg + 1'b1);
                                end
                                wr_en     = 1'b1;
                                tail_next = next_slot(tail_reg);
                            end
                        end
                        ctq_pkg::OP_DEQ: begin
                            if (occ_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = ctq_pkg::STAT_EMPTY;
                            end else begin
                                rd_en       = 1'b1;
                                teller_next = s_tdata[27:24];
                                head_next   = next_slot(head_reg);
                                occ_next    = CNT_W'(occ_reg - 1'b1);
                                state_next  = ctq_pkg::S_DEQ;
                            end
                        end
                        ctq_pkg::OP_FIND: begin
                            if (occ_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = ctq_pkg::STAT_NOT_FOUND;
                            end else begin
                                rd_en          = 1'b1;
                                key_next       = s_tdata[15:0];
                                scan_addr_next = next_slot(head_reg);
                                cmp_cnt_next   = '0;
                                state_next     = ctq_pkg::S_FIND;
                            end
                        end
                        ctq_pkg::OP_COUNT: begin
                            m_valid_next = 1'b1;
                            m_pos_next   = ctq_pkg::POS_W'(occ_reg);
                        end
                        default: begin
                            state_next = ctq_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            ctq_pkg::S_DEQ: begin
                // Head entry is in the read register; stamp the teller on the way out.
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_entry_next        = rd_data;
                    m_entry_next.teller = teller_reg;
                    state_next          = ctq_pkg::S_IDLE;
                end
            end
            ctq_pkg::S_FIND: begin
                // One entry compared per cycle while the next one is read.
                if (scan_hit || scan_last) begin
                    if (out_free) begin
                        m_valid_next  = 1'b1;
                        m_status_next = scan_hit ? ctq_pkg::STAT_OK
                                                 : ctq_pkg::STAT_NOT_FOUND;
                        m_pos_next    = scan_hit ? ctq_pkg::POS_W'(cmp_cnt_reg) : '0;
                        state_next    = ctq_pkg::S_IDLE;
                    end
                end else begin
                    rd_en          = 1'b1;
                    rd_addr        = scan_addr_reg;
                    scan_addr_next = next_slot(scan_addr_reg);
                    cmp_cnt_next   = IDX_W'(cmp_cnt_reg + 1'b1);
                end
            end
            default: begin
                state_next = ctq_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ctq_pkg::S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            owf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            occ_reg     <= occ_next;
            owf_reg     <= owf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        teller_reg    <= teller_next;
        scan_addr_reg <= scan_addr_next;
        cmp_cnt_reg   <= cmp_cnt_next;
        m_status_reg  <= m_status_next;
        m_pos_reg     <= m_pos_next;
        m_entry_reg   <= m_entry_next;
        m_drop_reg    <= m_drop_next;
    end

    // Output beat.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, m_entry_reg.teller, m_entry_reg.service,
                       m_entry_reg.kind, m_entry_reg.ticket, m_pos_reg};
    assign m_tuser  = {m_drop_reg, m_status_reg};

    // Occupancy never exceeds the queue depth.
    `CTQ_ASSERT_IMP(a_occ_bound, aclk, aresetn, 1'b1, occ_reg <= FULL_CNT)
    // An empty or full queue has head and tail on the same slot.
    `CTQ_ASSERT_IMP(a_ptr_meet, aclk, aresetn, (occ_reg == '0) || is_full, head_reg == tail_reg)
    // The scan never compares an entry beyond the occupied range.
    `CTQ_ASSERT_IMP(a_scan_range, aclk, aresetn, state_reg == ctq_pkg::S_FIND, CNT_W'(cmp_cnt_reg) < occ_reg)
    // A dequeue from a non-empty queue waits for the head entry read.
    `CTQ_ASSERT_NXT(a_deq_read, aclk, aresetn, s_fire && (in_op == ctq_pkg::OP_DEQ) && (occ_reg != '0), state_reg == ctq_pkg::S_DEQ)
    // Only a successful enqueue reports a dropped entry.
    `CTQ_ASSERT_IMP(a_drop_ok, aclk, aresetn, m_valid_reg && m_drop_reg, m_status_reg == ctq_pkg::STAT_OK)

endmodule

`default_nettype wire

FILE: hw/rtl/ctq_entry_ram.sv
// ----------------------------------------------------------------------------
// Ticket entry memory
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ctq_entry_ram #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  wire logic                aclk,
    input  wire logic                wr_en,
    input  wire logic [ADDR_W-1:0]   wr_addr,
    input  wire ctq_pkg::ctq_entry_t wr_data,
    input  wire logic                rd_en,
    input  wire logic [ADDR_W-1:0]   rd_addr,
    output ctq_pkg::ctq_entry_t      rd_data
);

    ctq_pkg::ctq_entry_t mem [DEPTH];
    ctq_pkg::ctq_entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Circular ticket queue testbench
// Drives enqueue, dequeue, find and count requests through the input stream,
// first from a short scripted table and then at random in phases that switch
// the full-queue mode, and checks every result beat against the scripted result or a
// queue model kept in step with the accepted requests.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH       = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int PHASE_BEATS = 150;
    localparam int PHASES      = 10;

    // One result beat, split into its fields.
    typedef struct packed {
        ctq_pkg::ctq_status_t      status;
        logic [ctq_pkg::POS_W-1:0] pos;
        ctq_pkg::ctq_entry_t       ent;
        logic                      dropped;
    } ticket_result_t;

    // One line of the scripted opening sequence.
    typedef struct {
        bit                  mode;
        ctq_pkg::ctq_op_t    op;
        int                  reps;
        ctq_pkg::ctq_entry_t fields;
        bit                  typed;
        ticket_result_t      result;
    } script_row_t;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic                          cfg_wdata = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [ctq_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic [ctq_pkg::S_TUSER_W-1:0] s_tuser   = '0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [ctq_pkg::M_TDATA_W-1:0] m_tdata;
    logic [ctq_pkg::M_TUSER_W-1:0] m_tuser;

    // Queue model state.
    ctq_pkg::ctq_entry_t slots [DEPTH];
    int                  head_slot  = 0;
    int                  tail_slot  = 0;
    int                  fill_level = 0;
    bit                  drop_oldest_mode = 1'b0;

    ticket_result_t pending_results [$];
    script_row_t    script [$];
    int             error_count  = 0;
    int             stall_cycles = 0;
    bit             tx_idle_on   = 1'b1;
    bit             rx_idle_on   = 1'b1;

    circular_ticket_queue #(
        .QUEUE_DEPTH (DEPTH)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Clock generation.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic int next_slot(int i);
        return (i == DEPTH - 1) ? 0 : i + 1;
    endfunction

    // Applies one request to the queue model and returns the result it gives.
    function automatic ticket_result_t apply_ticket_op(ctq_pkg::ctq_op_t op,
                                                       ctq_pkg::ctq_entry_t req);
        ticket_result_t r;
        int             slot;
        bit             found;
        r = '0;
        case (op)
            ctq_pkg::OP_ENQ: begin
                if (fill_level == DEPTH && !drop_oldest_mode) begin
                    r.status = ctq_pkg::STAT_FULL;
                end else begin
                    if (fill_level == DEPTH) begin
                        head_slot  = next_slot(head_slot);
                        fill_level = fill_level - 1;
                        r.dropped  = 1'b1;
                    end
                    slots[tail_slot] = req;
                    tail_slot  = next_slot(tail_slot);
                    fill_level = fill_level + 1;
                end
            end
            ctq_pkg::OP_DEQ: begin
                if (fill_level == 0) begin
                    r.status = ctq_pkg::STAT_EMPTY;
                end else begin
                    slots[head_slot].teller = req.teller;
                    r.ent      = slots[head_slot];
                    head_slot  = next_slot(head_slot);
                    fill_level = fill_level - 1;
                end
            end
            ctq_pkg::OP_FIND: begin
                r.status = ctq_pkg::STAT_NOT_FOUND;
                slot     = head_slot;
                found    = 1'b0;
                for (int i = 0; i < fill_level; i++) begin
                    if (!found && slots[slot].ticket == req.ticket) begin
                        found    = 1'b1;
                        r.status = ctq_pkg::STAT_OK;
                        r.pos    = ctq_pkg::POS_W'(i);
                    end
                    slot = next_slot(slot);
                end
            end
            default: begin
                r.pos = ctq_pkg::POS_W'(fill_level);
            end
        endcase
        return r;
    endfunction

    // Small ticket values make duplicates, so that find meets several matches.
    function automatic logic [ctq_pkg::TICKET_W-1:0] random_ticket();
        if ($urandom_range(0, 99) < 30)
            return ctq_pkg::TICKET_W'($urandom_range(0, 15));
        return ctq_pkg::TICKET_W'($urandom_range(0, 65535));
    endfunction

    // Find mostly looks for a ticket that is held somewhere in the queue.
    function automatic logic [ctq_pkg::TICKET_W-1:0] find_target();
        int slot;
        if (fill_level > 0 && $urandom_range(0, 99) < 70) begin
            slot = (head_slot + $urandom_range(0, fill_level - 1)) % DEPTH;
            return slots[slot].ticket;
        end
        return random_ticket();
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            error_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    function automatic void plan(bit mode, ctq_pkg::ctq_op_t op, int reps,
                                 logic [15:0] ticket, logic [3:0] kind,
                                 logic [3:0] service, logic [3:0] teller, bit typed,
                                 ctq_pkg::ctq_status_t status, int pos, bit dropped);
        script_row_t row;
        row.mode           = mode;
        row.op             = op;
        row.reps           = reps;
        row.fields.ticket  = ticket;
        row.fields.kind    = kind;
        row.fields.service = service;
        row.fields.teller  = teller;
        row.typed          = typed;
        row.result         = '0;
        row.result.status  = status;
        row.result.pos     = ctq_pkg::POS_W'(pos);
        row.result.dropped = dropped;
        script.push_back(row);
    endfunction

    // Sends one request beat, with an occasional gap in front of it.
    task automatic send_request(ctq_pkg::ctq_op_t op, ctq_pkg::ctq_entry_t f, bit typed,
                                ticket_result_t typed_result);
        ticket_result_t r;
        if (tx_idle_on && $urandom_range(0, 99) < 10) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, f.teller, f.service, f.kind, f.ticket};
        do @(posedge aclk); while (!s_tready);
        r = apply_ticket_op(op, f);
        pending_results.push_back(typed ? typed_result : r);
    endtask

    // The mode is only changed once every outstanding result has come back.
    task automatic write_mode(bit mode);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(posedge aclk);
        cfg_we <= 1'b0;
        drop_oldest_mode = mode;
    endtask

    // Result-side back-pressure.
    always @(posedge aclk) begin
        m_tready <= rx_idle_on ? ($urandom_range(0, 99) >= 10) : 1'b1;
    end

    // Result checking against the oldest expectation.
    always @(posedge aclk) begin
        ticket_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result beat, expected none, %s %h tuser %h",
                         $time, "actual tdata", m_tdata, m_tuser);
            end else begin
                want = pending_results.pop_front();
                check_field("status", 16'(want.status), 16'(m_tuser[1:0]));
                check_field("dropped_oldest", 16'(want.dropped), 16'(m_tuser[2]));
                check_field("position_or_count", 16'(want.pos), 16'(m_tdata[4:0]));
                check_field("out_ticket", want.ent.ticket, m_tdata[20:5]);
                check_field("out_customer_kind", 16'(want.ent.kind), 16'(m_tdata[24:21]));
                check_field("out_service_code", 16'(want.ent.service), 16'(m_tdata[28:25]));
                check_field("out_teller_code", 16'(want.ent.teller), 16'(m_tdata[32:29]));
                check_field("tdata padding", 16'h0, 16'(m_tdata[39:33]));
            end
        end
    end

    // Watchdog: ends the run when no beat moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        ctq_pkg::ctq_entry_t f;
        ctq_pkg::ctq_op_t    op;
        int                  roll;
        int                  enq_weight;
        int                  deq_weight;
        ticket_result_t      none;

        none = '0;

        // Opening script: empty queue, extreme fields, filling up, both full modes.
        plan(0, ctq_pkg::OP_DEQ,   1, 16'h0000, 4'h0, 4'h0, 4'h0, 1,
             ctq_pkg::STAT_EMPTY, 0, 0);
        plan(0, ctq_pkg::OP_FIND,  1, 16'h0000, 4'h0, 4'h0, 4'h0, 1,
             ctq_pkg::STAT_NOT_FOUND, 0, 0);
        plan(0, ctq_pkg::OP_COUNT, 1, 16'h0000, 4'h0, 4'h0, 4'h0, 1,
             ctq_pkg::STAT_OK, 0, 0);
        plan(0, ctq_pkg::OP_ENQ,   1, 16'hFFFF, 4'hF, 4'hF, 4'hF, 1,
             ctq_pkg::STAT_OK, 0, 0);
        plan(0, ctq_pkg::OP_ENQ,   1, 16'h0000, 4'h0, 4'h0, 4'h0, 1,
             ctq_pkg::STAT_OK, 0, 0);
        plan(0, ctq_pkg::OP_FIND,  1, 16'hFFFF, 4'h0, 4'h0, 4'h0, 1,
             ctq_pkg::STAT_OK, 0, 0);
        plan(0, ctq_pkg::OP_ENQ,  14, 16'h1000, 4'h5, 4'hA, 4'h3, 0,
             ctq_pkg::STAT_OK, 0, 0);
        plan(0, ctq_pkg::OP_COUNT, 1, 16'h0000, 4'h0, 4'h0, 4'h0, 1,
             ctq_pkg::STAT_OK, 16, 0);
        plan(0, ctq_pkg::OP_ENQ,   1, 16'h5555, 4'h2, 4'h4, 4'h8, 1,
             ctq_pkg::STAT_FULL, 0, 0);
        plan(0, ctq_pkg::OP_FIND,  1, 16'h100D, 4'h0, 4'h0, 4'h0, 0,
             ctq_pkg::STAT_OK, 0, 0);
        plan(1, ctq_pkg::OP_ENQ,   1, 16'hBEEF, 4'hC, 4'h6, 4'h1, 1,
             ctq_pkg::STAT_OK, 0, 1);
        plan(1, ctq_pkg::OP_COUNT, 1, 16'h0000, 4'h0, 4'h0, 4'h0, 1,
             ctq_pkg::STAT_OK, 16, 0);
        plan(1, ctq_pkg::OP_FIND,  1, 16'hFFFF, 4'h0, 4'h0, 4'h0, 1,
             ctq_pkg::STAT_NOT_FOUND, 0, 0);
        plan(1, ctq_pkg::OP_DEQ,   1, 16'h0000, 4'h0, 4'h0, 4'h9, 0,
             ctq_pkg::STAT_OK, 0, 0);
        plan(1, ctq_pkg::OP_DEQ,   1, 16'hFFFF, 4'hF, 4'hF, 4'hF, 0,
             ctq_pkg::STAT_OK, 0, 0);
        plan(1, ctq_pkg::OP_FIND,  1, 16'hBEEF, 4'h0, 4'h0, 4'h0, 0,
             ctq_pkg::STAT_OK, 0, 0);

        // Reset, then set the plain mode explicitly.
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_mode(1'b0);

        foreach (script[i]) begin
            if (script[i].mode != drop_oldest_mode)
                write_mode(script[i].mode);
            for (int rep = 0; rep < script[i].reps; rep++) begin
                f = script[i].fields;
                f.ticket = f.ticket + ctq_pkg::TICKET_W'(rep);
                send_request(script[i].op, f, script[i].typed, script[i].result);
            end
        end

        // Random phases; each boundary waits for the queue to drain its results.
        for (int phase = 0; phase < PHASES; phase++) begin
            write_mode(phase % 2 == 1);
            case (phase % 3)
                0:       enq_weight = 65;
                1:       enq_weight = 25;
                default: enq_weight = 45;
            endcase
            deq_weight = 70 - enq_weight;
            tx_idle_on = (phase != 4);
            rx_idle_on = (phase != 4);
            repeat (PHASE_BEATS) begin
                roll = $urandom_range(0, 99);
                if (roll < enq_weight)
                    op = ctq_pkg::OP_ENQ;
                else if (roll < enq_weight + deq_weight)
                    op = ctq_pkg::OP_DEQ;
                else if (roll < 90)
                    op = ctq_pkg::OP_FIND;
                else
                    op = ctq_pkg::OP_COUNT;
                f.ticket  = (op == ctq_pkg::OP_FIND) ? find_target() : random_ticket();
                f.kind    = ctq_pkg::CODE_W'($urandom_range(0, 15));
                f.service = ctq_pkg::CODE_W'($urandom_range(0, 15));
                f.teller  = ctq_pkg::CODE_W'($urandom_range(0, 15));
                send_request(op, f, 1'b0, none);
            end
        end

        // Drain and let any late beat show up.
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (error_count == 0 && pending_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/ctq_pkg.sv
hw/rtl/ctq_entry_ram.sv
hw/rtl/circular_ticket_queue.sv
verif/tb_top.sv
